FILE: rtl/core/dstf_pkg.sv
// Shared character codes, power-of-ten table and result type for the decimal parser.
package dstf_pkg;

  // Character codes recognized by the parser
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_CTRL_LO = 8'h07;
  localparam logic [7:0] CH_CTRL_HI = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam int VALUE_W = 64;

  // Powers of ten, 10^0 through 10^15
  localparam logic [63:0] POW10 [0:15] = '{
    64'd1,
    64'd10,
    64'd100,
    64'd1000,
    64'd10000,
    64'd100000,
    64'd1000000,
    64'd10000000,
    64'd100000000,
    64'd1000000000,
    64'd10000000000,
    64'd100000000000,
    64'd1000000000000,
    64'd10000000000000,
    64'd100000000000000,
    64'd1000000000000000
  };

  // One parsed number
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               bad_format;
  } result_t;

endpackage

FILE: rtl/core/decimal_string_to_fixed.sv
// Top level: ASCII decimal text to signed fixed point, one character per transaction.
// A terminator in the input register loads the result register when that is free.
// Throughput: one character per cycle; the input register stalls only when it
//   holds a terminator and the result register is full and stalled.
// Reset (rst, synchronous, active high) empties both registers and returns the
//   parser to the leading whitespace phase with cleared accumulators.
module decimal_string_to_fixed #(
  parameter int INT_BITS        = 31,
  parameter int FRAC_BITS       = 32,
  parameter int MAX_FRAC_DIGITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               char_valid,
  output logic                               char_stall,
  input  logic [7:0]                         char_code,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [dstf_pkg::VALUE_W-1:0] value,
  output logic                               bad_format
);

  logic              s1_valid;
  logic [7:0]        s1_char;
  logic              s1_term;
  logic              out_free;
  logic              s1_go;
  logic              load_out;
  dstf_pkg::result_t parsed;

  // Advance the input register unless a terminator waits on a full, stalled output
  assign s1_term    = (s1_char == dstf_pkg::CH_NUL);
  assign out_free   = !result_valid || !result_stall;
  assign s1_go      = s1_valid && (!s1_term || out_free);
  assign char_stall = s1_valid && !s1_go;
  assign load_out   = s1_go && s1_term;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!char_stall) begin
      s1_valid <= char_valid;
    end
    if (char_valid && !char_stall) begin
      s1_char <= char_code;
    end
  end

  dstf_acc #(
    .INT_BITS       (INT_BITS),
    .FRAC_BITS      (FRAC_BITS),
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
  ) u_acc (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_go),
    .char_code(s1_char),
    .result   (parsed)
  );

  // Result register: load on terminator, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (load_out) begin
      value      <= parsed.value;
      bad_format <= parsed.bad_format;
    end
  end

  // A loaded result is presented in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_out |=> result_valid)
    else $error("loaded result not presented");

  // A flagged result carries a zero value
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && bad_format) |-> (value == '0))
    else $error("bad format result with nonzero value");

  // Input only stalls behind a blocked terminator
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> (s1_valid && s1_term && result_valid && result_stall))
    else $error("input stalled without a blocked terminator");

endmodule

FILE: rtl/core/dstf_acc.sv
// Parser state machine and integer/fraction accumulators for one number.
module dstf_acc #(
  parameter int INT_BITS        = 31,
  parameter int FRAC_BITS       = 32,
  parameter int MAX_FRAC_DIGITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        char_code,
  output dstf_pkg::result_t result
);

  localparam int EXT_W = INT_BITS + 4;
  localparam int POS_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int IDX_W = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;

  typedef enum logic [1:0] {PH_SPACE, PH_INT, PH_FRAC, PH_SKIP} phase_t;

  phase_t               phase, phase_next;
  logic                 negative, negative_next;
  logic [INT_BITS-1:0]  int_acc, int_acc_next;
  logic [FRAC_BITS-1:0] frac_acc, frac_acc_next;
  logic [POS_W-1:0]     frac_pos, frac_pos_next;
  logic                 err_seen, err_seen_next;

  logic [FRAC_BITS-1:0] weight [MAX_FRAC_DIGITS];

  // Build fraction weights floor(2^FRAC_BITS / 10^(k+1)) at elaboration
  for (genvar k = 0; k < MAX_FRAC_DIGITS; k++) begin : g_weight
    localparam logic [63:0] WGT = (64'd1 << FRAC_BITS) / dstf_pkg::POW10[k+1];
    assign weight[k] = WGT[FRAC_BITS-1:0];
  end

  // Classify the character
  logic       is_term, is_digit, is_space, is_sign, is_point;
  logic [3:0] digit;

  assign is_term  = (char_code == dstf_pkg::CH_NUL);
  assign is_digit = (char_code >= dstf_pkg::CH_ZERO) && (char_code <= dstf_pkg::CH_NINE);
  assign is_space = ((char_code >= dstf_pkg::CH_CTRL_LO) && (char_code <= dstf_pkg::CH_CTRL_HI))
                    || (char_code == dstf_pkg::CH_SPACE);
  assign is_sign  = (char_code == dstf_pkg::CH_PLUS) || (char_code == dstf_pkg::CH_MINUS);
  assign is_point = (char_code == dstf_pkg::CH_POINT);
  assign digit    = char_code[3:0];

  // Integer digit: multiply by ten, add, saturate
  logic [EXT_W-1:0]    int_wide;
  logic [INT_BITS-1:0] int_sat;

  assign int_wide = (EXT_W'(int_acc) << 3) + (EXT_W'(int_acc) << 1) + EXT_W'(digit);
  assign int_sat  = (int_wide > EXT_W'({INT_BITS{1'b1}})) ? {INT_BITS{1'b1}}
                                                          : int_wide[INT_BITS-1:0];

  // Fraction digit: add digit times the weight of the next position
  logic [FRAC_BITS+3:0] frac_term;
  logic [FRAC_BITS-1:0] frac_sum;

  assign frac_term = (FRAC_BITS + 4)'(digit) * (FRAC_BITS + 4)'(weight[frac_pos[IDX_W-1:0]]);
  assign frac_sum  = frac_acc + frac_term[FRAC_BITS-1:0];

  // Work out the next parser state
  logic take_int;

  assign take_int = (phase == PH_INT) || ((phase == PH_SPACE) && !is_space && !is_sign);

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    int_acc_next  = int_acc;
    frac_acc_next = frac_acc;
    frac_pos_next = frac_pos;
    err_seen_next = err_seen;
    case (phase)
      PH_SPACE: begin
        if (is_sign) begin
          negative_next = (char_code == dstf_pkg::CH_MINUS);
          phase_next    = PH_INT;
        end else if (!is_space) begin
          phase_next = PH_INT;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (frac_pos < POS_W'(MAX_FRAC_DIGITS)) begin
            frac_pos_next = frac_pos + POS_W'(1);
            frac_acc_next = frac_sum;
          end
        end else begin
          phase_next = PH_SKIP;
        end
      end
      default: ;
    endcase
    if (take_int) begin
      if (is_digit) begin
        int_acc_next = int_sat;
      end else if (is_point) begin
        phase_next = PH_FRAC;
      end else begin
        err_seen_next = 1'b1;
        phase_next    = PH_SKIP;
      end
    end
  end

  // Hold state; clear it on reset and at the end of each number
  always_ff @(posedge clk) begin
    if (rst || (step && is_term)) begin
      phase    <= PH_SPACE;
      negative <= 1'b0;
      int_acc  <= '0;
      frac_acc <= '0;
      frac_pos <= '0;
      err_seen <= 1'b0;
    end else if (step) begin
      phase    <= phase_next;
      negative <= negative_next;
      int_acc  <= int_acc_next;
      frac_acc <= frac_acc_next;
      frac_pos <= frac_pos_next;
      err_seen <= err_seen_next;
    end
  end

  // Assemble the signed fixed-point result from the current state
  logic [dstf_pkg::VALUE_W-1:0] magnitude;

  assign magnitude = (dstf_pkg::VALUE_W'(int_acc) << FRAC_BITS)
                     | dstf_pkg::VALUE_W'(frac_acc);

  always_comb begin
    result.bad_format = err_seen;
    if (err_seen) begin
      result.value = '0;
    end else if (negative) begin
      result.value = '0 - magnitude;
    end else begin
      result.value = magnitude;
    end
  end

  // An error always parks the parser until the terminator
  a_err_skip: assert property (@(posedge clk) disable iff (rst)
    err_seen |-> (phase == PH_SKIP))
    else $error("error flag set outside skip phase");

  // Fraction position never runs past the digit limit
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    frac_pos <= POS_W'(MAX_FRAC_DIGITS))
    else $error("fraction position out of range");

  // Terminator returns the accumulators to their cleared state
  a_term_clear: assert property (@(posedge clk) disable iff (rst)
    (step && is_term) |=> (int_acc == '0) && (frac_acc == '0) && !negative && !err_seen)
    else $error("state not cleared after terminator");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the decimal text to fixed point parser, with a scoreboard class.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INT_W      = 31;
  localparam int FRAC_W     = 32;
  localparam int FRAC_DIGITS = 10;
  localparam int RANDOM_CHARS = 1620;

  // Predict parsed numbers from accepted characters and check results in order
  class fixed_scoreboard;
    typedef enum {SKIP_SPACE, TAKE_INT, TAKE_FRAC, IGNORE_REST} parse_phase_e;

    parse_phase_e phase;
    bit           negative;
    bit [63:0]    int_acc;
    bit [63:0]    frac_acc;
    int           frac_pos;
    bit           err_seen;
    bit [63:0]    exp_value[$];
    bit           exp_bad[$];
    int           failures;

    function new();
      failures = 0;
      clear();
    endfunction

    function void clear();
      phase    = SKIP_SPACE;
      negative = 1'b0;
      int_acc  = '0;
      frac_acc = '0;
      frac_pos = 0;
      err_seen = 1'b0;
    endfunction

    function bit is_blank(bit [7:0] c);
      return (c >= dstf_pkg::CH_CTRL_LO && c <= dstf_pkg::CH_CTRL_HI)
             || c == dstf_pkg::CH_SPACE;
    endfunction

    function bit is_digit(bit [7:0] c);
      return c >= dstf_pkg::CH_ZERO && c <= dstf_pkg::CH_NINE;
    endfunction

    // floor(2^FRAC_W / 10^k)
    function bit [63:0] digit_weight(int k);
      bit [63:0] p;
      p = 64'd1;
      for (int i = 0; i < k; i++) p = p * 64'd10;
      return (64'd1 << FRAC_W) / p;
    endfunction

    function void note_char(bit [7:0] c);
      bit [63:0] v;
      bit [63:0] lim;
      bit [63:0] d;
      lim = (64'd1 << INT_W) - 64'd1;
      d   = 64'(c - dstf_pkg::CH_ZERO);
      // Terminator: emit the number and start over
      if (c == dstf_pkg::CH_NUL) begin
        v = '0;
        if (!err_seen) begin
          v = (int_acc << FRAC_W) | frac_acc;
          if (negative) v = 64'd0 - v;
        end
        exp_value.push_back(v);
        exp_bad.push_back(err_seen);
        clear();
        return;
      end
      // Leading blanks and one optional sign
      if (phase == SKIP_SPACE) begin
        if (is_blank(c)) return;
        phase = TAKE_INT;
        if (c == dstf_pkg::CH_PLUS || c == dstf_pkg::CH_MINUS) begin
          negative = (c == dstf_pkg::CH_MINUS);
          return;
        end
      end
      case (phase)
        TAKE_INT: begin
          if (is_digit(c)) begin
            v = int_acc * 64'd10 + d;
            int_acc = (v > lim) ? lim : v;
          end else if (c == dstf_pkg::CH_POINT) begin
            phase = TAKE_FRAC;
          end else begin
            err_seen = 1'b1;
            phase    = IGNORE_REST;
          end
        end
        TAKE_FRAC: begin
          if (is_digit(c)) begin
            if (frac_pos < FRAC_DIGITS) begin
              frac_pos++;
              frac_acc += d * digit_weight(frac_pos);
            end
          end else begin
            phase = IGNORE_REST;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(bit [63:0] value, bit bad_format);
      bit [63:0] ev;
      bit        eb;
      if (exp_value.size() == 0) begin
        $display("%0t: unexpected result, value %h bad_format %b", $realtime, value, bad_format);
        failures++;
        return;
      end
      ev = exp_value.pop_front();
      eb = exp_bad.pop_front();
      if (value !== ev) begin
        $display("%0t: value mismatch, expected %h actual %h", $realtime, ev, value);
        failures++;
      end
      if (bad_format !== eb) begin
        $display("%0t: bad_format mismatch, expected %b actual %b", $realtime, eb, bad_format);
        failures++;
      end
    endfunction

    function int pending();
      return exp_value.size();
    endfunction

    function bit clean();
      return failures == 0 && exp_value.size() == 0;
    endfunction
  endclass

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              char_valid   = 1'b0;
  logic              char_stall;
  logic [7:0]        char_code    = 8'h00;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic signed [63:0] value;
  logic              bad_format;

  fixed_scoreboard sb = new();
  logic [7:0]      text_q[$];
  int              chars_taken  = 0;
  int              results_seen = 0;
  int              hold_left    = 0;
  bit              hold_done    = 1'b0;

  decimal_string_to_fixed #(
    .INT_BITS       (INT_W),
    .FRAC_BITS      (FRAC_W),
    .MAX_FRAC_DIGITS(FRAC_DIGITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .value       (value),
    .bad_format  (bad_format)
  );

  always #4 clk = ~clk;

  // Queue one number text followed by its terminator
  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    text_q.push_back(dstf_pkg::CH_NUL);
  endtask

  function automatic logic [7:0] pick_blank();
    int n;
    n = $urandom_range(7);
    return (n == 7) ? dstf_pkg::CH_SPACE : 8'(dstf_pkg::CH_CTRL_LO + n);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(dstf_pkg::CH_ZERO + $urandom_range(9));
  endfunction

  // Any nonzero code, weighted toward the characters the parser cares about
  function automatic logic [7:0] pick_any();
    case ($urandom_range(7))
      0: return pick_blank();
      1: return pick_digit();
      2: return dstf_pkg::CH_POINT;
      3: return ($urandom_range(1) != 0) ? dstf_pkg::CH_PLUS : dstf_pkg::CH_MINUS;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic add_random_number();
    int mode;
    int n;
    mode = $urandom_range(99);
    if (mode < 75) begin
      // Mostly well-formed number with random content, now and then followed by stray characters
      repeat ($urandom_range(3)) text_q.push_back(pick_blank());
      case ($urandom_range(3))
        0: text_q.push_back(dstf_pkg::CH_PLUS);
        1: text_q.push_back(dstf_pkg::CH_MINUS);
        default: ;
      endcase
      n = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(4);
      repeat (n) text_q.push_back(pick_digit());
      if ($urandom_range(3) != 0) begin
        text_q.push_back(dstf_pkg::CH_POINT);
        n = ($urandom_range(7) == 0) ? $urandom_range(14) : $urandom_range(5);
        repeat (n) text_q.push_back(pick_digit());
      end
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) text_q.push_back(pick_any());
    end else if (mode < 90) begin
      // Likely broken number: random character inside the integer part
      if ($urandom_range(1) != 0) text_q.push_back(dstf_pkg::CH_MINUS);
      repeat ($urandom_range(3)) text_q.push_back(pick_digit());
      text_q.push_back(8'($urandom_range(1, 255)));
      repeat ($urandom_range(4)) text_q.push_back(pick_any());
    end else begin
      // Noise
      repeat ($urandom_range(6)) text_q.push_back(pick_any());
    end
    text_q.push_back(dstf_pkg::CH_NUL);
  endtask

  task automatic build_directed();
    add_text("");
    add_text("-");
    add_text(".");
    add_text("+");
    add_text("0");
    add_text("-0.0");
    add_text(" \011\012+12.5");
    add_text("\007\015\0401");
    add_text("\0061");
    add_text("\0161");
    add_text("- 5");
    add_text("12x");
    add_text("++1");
    add_text("9/");
    add_text("9:");
    add_text("3.14abc");
    add_text("1..2");
    add_text(".5");
    add_text("-.5");
    add_text("1.123456789012345");
    add_text("0.9876543210");
    add_text("2147483647.9999999999");
    add_text("-2147483647.9999999999");
    add_text("99999999999");
    add_text("-2147483648");
    add_text("\377");
    add_text("\200");
    add_text("7\377");
  endtask

  function automatic bit sender_pause();
    if (chars_taken >= 700 && chars_taken < 1100) return 1'b0;
    return $urandom_range(99) < 36;
  endfunction

  function automatic bit receiver_pause();
    if (results_seen >= 90 && results_seen < 130) return 1'b0;
    return $urandom_range(99) < 36;
  endfunction

  // Offer characters; hold the payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      char_code  <= dstf_pkg::CH_NUL;
    end else begin
      if (char_valid && !char_stall) begin
        sb.note_char(char_code);
        chars_taken = chars_taken + 1;
      end
      if (!char_valid || !char_stall) begin
        if (chars_taken < text_q.size() && !sender_pause()) begin
          char_valid <= 1'b1;
          char_code  <= text_q[chars_taken];
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // Check results and drive stall, with one long hold-off to back up the parser
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        sb.check_result(value, bad_format);
        results_seen = results_seen + 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        result_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = 400;
        result_stall <= 1'b1;
      end else begin
        result_stall <= receiver_pause();
      end
    end
  end

  initial begin
    int directed_len;
    build_directed();
    directed_len = text_q.size();
    while (text_q.size() < directed_len + RANDOM_CHARS) add_random_number();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // Drain: every character taken and every number returned
    while (chars_taken < text_q.size() || sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.clean()) begin
      $display("decimal_string_to_fixed verification clean");
    end else begin
      $display("decimal_string_to_fixed verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d results outstanding", $realtime, sb.pending());
    $display("decimal_string_to_fixed verification failed");
    $finish;
  end

endmodule
